/* hw/rtl/kmde_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmde_pkg
// shared constants and controller/datapath handshake types for the key
// matrix debounce block
// ----------------------------------------------------------------------------
package kmde_pkg;

   localparam int ROW_COUNT_DEF    = 8;
   localparam int COLUMN_COUNT_DEF = 16;

   // fixed field widths
   localparam int COLUMN_W   = 4;
   localparam int ROW_BITS_W = 8;
   localparam int ROW_IDX_W  = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;
   // wide enough to compare any column with the largest column count
   localparam int COLUMN_EXT_W = 7;

   // event kinds
   localparam logic EVT_KEY    = 1'b0;
   localparam logic EVT_REPORT = 1'b1;

   typedef struct packed {
      logic capture;
      logic update;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pend_event;
      logic pend_report;
      logic slot_free;
      logic emit_last;
   } ctrl_status_type;

endpackage

/* hw/rtl/kmde_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmde_datapath
// column state memory, debounce logic, change walker and result register
// ----------------------------------------------------------------------------
module kmde_datapath #(
   parameter int ROW_COUNT    = kmde_pkg::ROW_COUNT_DEF,
   parameter int COLUMN_COUNT = kmde_pkg::COLUMN_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  kmde_pkg::ctrl_cmd_type              cmd,
   output kmde_pkg::ctrl_status_type           status,
   // column [3:0], row_bits [11:4], zero fill
   input  logic [kmde_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // key_row [2:0], key_column [6:3], key_down [7]
   output logic [kmde_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // event_kind [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import kmde_pkg::*;

   localparam int CIDX_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;

   logic [2*ROW_COUNT-1:0]   mem [COLUMN_COUNT];
   logic [COLUMN_COUNT-1:0]  valid_ff, valid_in;

   logic [COLUMN_W-1:0]      col_ff;
   logic [ROW_COUNT-1:0]     sample_ff;
   logic                     end_ff;
   logic                     in_range_ff;
   logic [2*ROW_COUNT-1:0]   rd_ff;
   logic                     rd_valid_ff;

   logic [ROW_COUNT-1:0]     diff_ff, diff_in;
   logic [ROW_COUNT-1:0]     stable_ff, stable_in;
   logic                     rep_pend_ff, rep_pend_in;
   logic                     had_change_ff, had_change_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [ROW_IDX_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [COLUMN_W-1:0]      rsp_col_ff, rsp_col_in;
   logic                     rsp_down_ff, rsp_down_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [COLUMN_EXT_W-1:0]  req_col_ext;
   logic [CIDX_W-1:0]        req_idx;
   logic [CIDX_W-1:0]        cur_idx;
   logic [ROW_COUNT-1:0]     prev_raw;
   logic [ROW_COUNT-1:0]     prev_deb;
   logic [ROW_COUNT-1:0]     stable_now;
   logic [ROW_COUNT-1:0]     diff_now;
   logic [ROW_COUNT-1:0]     diff_rest;
   logic [ROW_IDX_W-1:0]     low_row;
   logic                     mem_we;

   function automatic logic req_end_report(input logic                 scan_end,
                                           input logic                 had_change,
                                           input logic [ROW_COUNT-1:0] diff);
      req_end_report = scan_end && (had_change || (diff != '0));
   endfunction

   assign req_col_ext = COLUMN_EXT_W'(req_tdata[COLUMN_W-1:0]);
   assign req_idx     = req_col_ext[CIDX_W-1:0];
   assign cur_idx     = CIDX_W'(COLUMN_EXT_W'(col_ff));

   // stored state, zero until the column has been written once
   assign prev_raw   = rd_valid_ff ? rd_ff[ROW_COUNT-1:0] : '0;
   assign prev_deb   = rd_valid_ff ? rd_ff[2*ROW_COUNT-1:ROW_COUNT] : '0;
   assign stable_now = prev_raw & sample_ff;
   assign diff_now   = in_range_ff ? (prev_deb ^ stable_now) : '0;
   assign mem_we     = cmd.update && in_range_ff;

   // lowest changed row first
   assign diff_rest = diff_ff & (diff_ff - ROW_COUNT'(1));

   always_comb begin
      low_row = '0;
      for (int r = ROW_COUNT - 1; r >= 0; r--) begin
         if (diff_ff[r]) begin
            low_row = ROW_IDX_W'(r);
         end
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      diff_in       = diff_ff;
      stable_in     = stable_ff;
      rep_pend_in   = rep_pend_ff;
      had_change_in = had_change_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_down_in   = rsp_down_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (mem_we) begin
         valid_in[cur_idx] = 1'b1;
      end

      if (cmd.update) begin
         diff_in   = diff_now;
         stable_in = stable_now;
         if (req_end_report(end_ff, had_change_ff, diff_now)) begin
            rep_pend_in   = 1'b1;
            had_change_in = 1'b0;
         end else begin
            rep_pend_in   = 1'b0;
            had_change_in = had_change_ff || (diff_now != '0);
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (diff_ff != '0) begin
            rsp_kind_in = EVT_KEY;
            rsp_row_in  = low_row;
            rsp_col_in  = col_ff;
            rsp_down_in = stable_ff[low_row];
            rsp_last_in = (diff_rest == '0) && !rep_pend_ff;
            diff_in     = diff_rest;
         end else begin
            rsp_kind_in = EVT_REPORT;
            rsp_row_in  = '0;
            rsp_col_in  = '0;
            rsp_down_in = 1'b0;
            rsp_last_in = 1'b1;
            rep_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff <= mem[req_idx];
      end
      if (mem_we) begin
         mem[cur_idx] <= {stable_now, sample_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff      <= req_tdata[COLUMN_W-1:0];
         sample_ff   <= req_tdata[COLUMN_W +: ROW_COUNT];
         end_ff      <= req_tlast;
         in_range_ff <= req_col_ext < COLUMN_EXT_W'(COLUMN_COUNT);
         rd_valid_ff <= valid_ff[req_idx];
      end
      stable_ff   <= stable_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_down_ff <= rsp_down_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         diff_ff       <= '0;
         rep_pend_ff   <= 1'b0;
         had_change_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         diff_ff       <= diff_in;
         rep_pend_ff   <= rep_pend_in;
         had_change_ff <= had_change_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign status.pend_event  = diff_ff != '0;
   assign status.pend_report = rep_pend_ff;
   assign status.slot_free   = !rsp_valid_ff || rsp_tready;
   assign status.emit_last   = (diff_ff != '0) ? ((diff_rest == '0) && !rep_pend_ff) : 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_down_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_last_clears_work: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.emit_last |=> (diff_ff == '0) && !rep_pend_ff)
      else $error("work left after final result");

   a_out_of_range_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.update && !in_range_ff |=> diff_ff == '0)
      else $error("key event for column beyond matrix");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == EVT_REPORT) |->
         (rsp_row_ff == '0) && (rsp_col_ff == '0) && !rsp_down_ff && rsp_last_ff)
      else $error("report request with key fields set");
`endif

endmodule

/* hw/rtl/kmde_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmde_controller
// sequences capture, state lookup and result emission for one column
// ----------------------------------------------------------------------------
module kmde_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  kmde_pkg::ctrl_status_type status,
   output kmde_pkg::ctrl_cmd_type    cmd
);
   import kmde_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       work_left;

   assign work_left   = status.pend_event || status.pend_report;
   assign req_tready  = state_ff == ST_IDLE;
   assign cmd.capture = req_tready && req_tvalid;
   assign cmd.update  = state_ff == ST_LOOKUP;
   assign cmd.emit    = (state_ff == ST_EMIT) && work_left && status.slot_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!work_left || (cmd.emit && status.emit_last)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_capture_then_lookup: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_LOOKUP) && !req_tready)
      else $error("transfer not followed by lookup");

   a_lookup_then_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_EMIT)
      else $error("lookup not followed by emission");
`endif

endmodule

/* hw/rtl/key_matrix_debounce_events.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_events
// two-sample debounce of a scanned key matrix with key change events
// ----------------------------------------------------------------------------
// Each request transfer carries one scanned column. A key is pressed once two
// consecutive samples of its column show it closed and released as soon as one
// shows it open. Every changed key gives one event (lowest row first); on the
// last column of a scan a report request follows if any key changed during the
// scan. A column occupies the block through its capture, the state lookup and
// one emission per result (one to nine), or one pass through the emit state
// when it causes none, plus any response side stalls: results leave one per
// cycle via the output register, after a registered read of the state memory.
// The next column is taken while the last result still waits to be taken.
// ----------------------------------------------------------------------------
module key_matrix_debounce_events #(
   parameter int ROW_COUNT    = kmde_pkg::ROW_COUNT_DEF,
   parameter int COLUMN_COUNT = kmde_pkg::COLUMN_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // column [3:0], row_bits [11:4], zero fill
   input  logic [kmde_pkg::REQ_DATA_W-1:0] req_tdata,
   // scan_end
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // key_row [2:0], key_column [6:3], key_down [7]
   output logic [kmde_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // event_kind [0]
   output logic                            rsp_tuser,
   // run_last
   output logic                            rsp_tlast
);
   import kmde_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   kmde_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kmde_datapath #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/key_matrix_debounce_events_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_events_tb
// self-checking bench for the two-sample key matrix debounce block
// ----------------------------------------------------------------------------
// Columns are sent as request transfers: a directed opening covers full press
// and release of a column, alternating rows, bounces and scan ends with and
// without a change. Then come whole and broken matrix scans over a slowly
// changing set of held keys with contact bounce, mixed with random columns.
// A debounce tracker keeps its own copy of the column state, predicts the key
// events and report requests of each column and checks every response
// transfer against the oldest one waiting. Both sides idle in random bursts,
// except in the last part of the run.
// ----------------------------------------------------------------------------
module key_matrix_debounce_events_tb;

   import kmde_pkg::*;

   localparam int ROWS         = ROW_COUNT_DEF;
   localparam int COLUMNS      = COLUMN_COUNT_DEF;
   localparam int ROW_MASK     = (1 << ROWS) - 1;
   localparam int RANDOM_ITEMS = 160;
   localparam int CALM_FROM    = 130;
   localparam int DRAIN_CYCLES = 20;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic                 kind;
      logic [ROW_IDX_W-1:0] row;
      logic [COLUMN_W-1:0]  col;
      logic                 down;
      logic                 last;
   } key_event_type;

   class debounce_tracker;
      logic [ROW_BITS_W-1:0] prev_sample [COLUMNS];
      logic [ROW_BITS_W-1:0] stable_keys [COLUMNS];
      logic                  change_seen;
      key_event_type         pending_events [$];
      int                    errors;

      function new();
         foreach (prev_sample[i]) begin
            prev_sample[i] = '0;
            stable_keys[i] = '0;
         end
         change_seen = 1'b0;
         errors = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("mismatch at %0t: %s", $realtime, what);
      endtask

      function void note_column(input logic [COLUMN_W-1:0] col,
                                input logic [ROW_BITS_W-1:0] bits,
                                input logic scan_end);
         logic [ROW_BITS_W-1:0] sample;
         logic [ROW_BITS_W-1:0] stable;
         logic [ROW_BITS_W-1:0] diff;
         key_event_type         ev;
         int                    made;
         made = 0;
         sample = bits & ROW_BITS_W'(ROW_MASK);
         if (int'(col) < COLUMNS) begin
            stable = prev_sample[col] & sample;
            diff = (stable_keys[col] ^ stable) & ROW_BITS_W'(ROW_MASK);
            for (int r = 0; r < ROWS; r++) begin
               if (diff[r]) begin
                  ev.kind = EVT_KEY;
                  ev.row  = ROW_IDX_W'(r);
                  ev.col  = col;
                  ev.down = stable[r];
                  ev.last = 1'b0;
                  pending_events.push_back(ev);
                  made++;
               end
            end
            prev_sample[col] = sample;
            stable_keys[col] = stable;
            if (diff != '0) change_seen = 1'b1;
         end
         if (scan_end && change_seen) begin
            ev = '0;
            ev.kind = EVT_REPORT;
            pending_events.push_back(ev);
            made++;
            change_seen = 1'b0;
         end
         if (made > 0) begin
            ev = pending_events[$];
            pending_events.pop_back();
            ev.last = 1'b1;
            pending_events.push_back(ev);
         end
      endfunction

      task check_event(input key_event_type got);
         key_event_type want;
         if (pending_events.size() == 0) begin
            report($sformatf("unexpected result kind %0d row %0d col %0d down %0d",
                             got.kind, got.row, got.col, got.down));
         end else begin
            want = pending_events.pop_front();
            if (got.kind !== want.kind)
               report($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
            if (got.row !== want.row)
               report($sformatf("key_row %0d, want %0d", got.row, want.row));
            if (got.col !== want.col)
               report($sformatf("key_column %0d, want %0d", got.col, want.col));
            if (got.down !== want.down)
               report($sformatf("key_down %0d, want %0d", got.down, want.down));
            if (got.last !== want.last)
               report($sformatf("run_last %0d, want %0d", got.last, want.last));
         end
      endtask
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   debounce_tracker       tracker;
   logic                  calm       = 1'b0;
   int                    items_sent = 0;
   int                    stall_left = 0;
   int                    quiet_cycles = 0;
   logic [ROW_BITS_W-1:0] held_keys [COLUMNS];
   key_event_type         got_event;

   always #5 clock = ~clock;

   key_matrix_debounce_events #(
      .ROW_COUNT    (ROWS),
      .COLUMN_COUNT (COLUMNS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // one column per request transfer, with an occasional gap before it
   task send_column(input logic [COLUMN_W-1:0] col, input logic [ROW_BITS_W-1:0] bits,
                    input logic scan_end);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, bits, col};
      req_tlast  <= scan_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_column(col, bits, scan_end);
      items_sent++;
      if (items_sent >= CALM_FROM) calm = 1'b1;
   endtask

   // held keys change now and then; the sample may carry a bouncing contact
   task scan_matrix(input int last_col);
      logic [ROW_BITS_W-1:0] sample;
      for (int c = 0; c <= last_col; c++) begin
         if ($urandom_range(0, 2) == 0)
            held_keys[c] = held_keys[c] ^ (ROW_BITS_W'(1) << $urandom_range(0, ROWS - 1));
         sample = held_keys[c];
         if ($urandom_range(0, 5) == 0)
            sample = sample ^ (ROW_BITS_W'(1) << $urandom_range(0, ROWS - 1));
         send_column(COLUMN_W'(c), sample, c == last_col);
      end
   endtask

   // response side: check each transfer, then pick the next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_event.kind = rsp_tuser;
         got_event.row  = rsp_tdata[2:0];
         got_event.col  = rsp_tdata[6:3];
         got_event.down = rsp_tdata[7];
         got_event.last = rsp_tlast;
         tracker.check_event(got_event);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 9) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      tracker = new();
      foreach (held_keys[i]) held_keys[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_column(4'd0, 8'hFF, 1'b0);
      send_column(4'd0, 8'hFF, 1'b0);
      send_column(4'd0, 8'hFF, 1'b1);
      send_column(4'd0, 8'hFF, 1'b1);
      send_column(4'd0, 8'h00, 1'b0);
      send_column(4'd15, 8'hAA, 1'b0);
      send_column(4'd15, 8'hAA, 1'b1);
      send_column(4'd15, 8'h55, 1'b0);
      send_column(4'd15, 8'h55, 1'b0);
      send_column(4'd7, 8'h01, 1'b0);
      send_column(4'd7, 8'h00, 1'b0);
      send_column(4'd7, 8'h80, 1'b0);
      send_column(4'd7, 8'h80, 1'b1);
      send_column(4'd15, 8'h00, 1'b1);
      send_column(4'd10, 8'hFF, 1'b0);
      send_column(4'd5, 8'hFF, 1'b0);
      send_column(4'd10, 8'h7E, 1'b1);
      send_column(4'd0, 8'h00, 1'b1);

      // random scans, broken scans and stray columns
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: begin
               repeat ($urandom_range(1, 4))
                  send_column(COLUMN_W'($urandom_range(0, 15)),
                              ROW_BITS_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
            end
            1: begin
               scan_matrix($urandom_range(0, COLUMNS - 2));
            end
            default: begin
               scan_matrix(COLUMNS - 1);
            end
         endcase
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending_events.size() != 0)
         tracker.report("results still outstanding at the end");
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/kmde_pkg.sv
hw/rtl/kmde_datapath.sv
hw/rtl/kmde_controller.sv
hw/rtl/key_matrix_debounce_events.sv
tb/key_matrix_debounce_events_tb.sv
